// ===== hw/rtl/vq_codebook_block_decoder_top_assert.svh =====
// assertion macros for the vq codebook block decoder
`ifndef VQ_CODEBOOK_BLOCK_DECODER_TOP_ASSERT_SVH
`define VQ_CODEBOOK_BLOCK_DECODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off while in reset
`define VQCBD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("vqcbd same-cycle check failed");

// next-cycle implication, sampled on clk, off while in reset
`define VQCBD_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("vqcbd next-cycle check failed");

`endif

// ===== hw/rtl/vqcbd_pkg.sv =====
// shared types and constants of the vq codebook block decoder
package vqcbd_pkg;

	// command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_DECODE = 1'b1;

	// register indexes
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_TALL_BLOCKS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FILL_MARKER    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_PER_ROW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_ROWS     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE     = 3'd4;
	localparam int unsigned CFG_DATA_W = 13;

	// register reset values
	localparam logic [7:0]  FILL_MARKER_RST    = 8'd15;
	localparam logic [10:0] BLOCKS_PER_ROW_RST = 11'd80;
	localparam logic [10:0] BLOCK_ROWS_RST     = 11'd50;
	localparam logic [12:0] ROW_STRIDE_RST     = 13'd320;

	// output queue depth
	localparam int unsigned OUT_DEPTH = 4;
	localparam int unsigned OUT_PTR_W = 2;
	localparam int unsigned OUT_CNT_W = 3;

	// one result item
	typedef struct packed {
		logic [23:0] byte_address;
		logic [31:0] pixel_word;
		logic        block_last;
		logic        frame_done;
		logic        bad_entry;
	} out_item_t;

	// row word in flight alongside its codebook read
	typedef struct packed {
		logic [23:0] byte_address;
		logic [31:0] pixel_word;
		logic        use_mem;
		logic        block_last;
		logic        frame_done;
		logic        bad_entry;
	} row_meta_t;

endpackage

// ===== hw/rtl/vqcbd_codebook.sv =====
// codebook store: single-port write, registered read
module vqcbd_codebook
	import vqcbd_pkg::*;
#(
	parameter int unsigned CODEBOOK_ENTRIES = 4096
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [$clog2(CODEBOOK_ENTRIES*4)-1:0]    wr_addr,
	input  logic [31:0]                              wr_data,
	input  logic                                     rd_en,
	input  logic [$clog2(CODEBOOK_ENTRIES*4)-1:0]    rd_addr,
	output logic [31:0]                              rd_data
);

	localparam int unsigned WORDS = CODEBOOK_ENTRIES * 4;

	logic [31:0] mem [0:WORDS-1];
	logic [31:0] rd_data_q;

	// read returns the word as it stood before a write on the same edge
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/vqcbd_out_fifo.sv =====
// small result queue between the read pipeline and the output port
module vqcbd_out_fifo
	import vqcbd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  out_item_t            push_item,
	input  logic                 pop,
	output logic                 not_empty,
	output out_item_t            head,
	output logic [OUT_CNT_W-1:0] count
);

	out_item_t              buf_q [0:OUT_DEPTH-1];
	logic [OUT_PTR_W-1:0]   wr_ptr_q;
	logic [OUT_PTR_W-1:0]   rd_ptr_q;
	logic [OUT_CNT_W-1:0]   count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign not_empty = (count_q != '0);
	assign head      = buf_q[rd_ptr_q];
	assign count     = count_q;

endmodule

// ===== hw/rtl/vqcbd_sequencer.sv =====
// configuration, frame position and per-row read sequencing
`include "vq_codebook_block_decoder_top_assert.svh"

module vqcbd_sequencer
	import vqcbd_pkg::*;
#(
	parameter int unsigned CODEBOOK_ENTRIES = 4096,
	parameter int unsigned ADDRESS_BITS     = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [CFG_IDX_W-1:0]                  cfg_index,
	input  logic [CFG_DATA_W-1:0]                 cfg_data,
	input  logic                                  in_valid,
	input  logic                                  command,
	input  logic [7:0]                            pointer_low,
	input  logic [7:0]                            pointer_high,
	input  logic                                  space,
	output logic                                  in_ready,
	output logic                                  rd_en,
	output logic [$clog2(CODEBOOK_ENTRIES*4)-1:0] rd_addr,
	output row_meta_t                             meta
);

	localparam int unsigned AW = ADDRESS_BITS;
	localparam int unsigned SW = $clog2(CODEBOOK_ENTRIES * 4);
	localparam logic [16:0] ENTRIES = 17'(CODEBOOK_ENTRIES);

	// configuration registers
	logic        tall_q;
	logic [7:0]  fill_marker_q;
	logic [10:0] bpr_q;
	logic [10:0] brows_q;
	logic [12:0] stride_q;

	// frame position
	logic [AW-1:0] row_base_q;
	logic [AW-1:0] column_q;
	logic [10:0]   blocks_left_q;
	logic [10:0]   rows_done_q;

	// block being read out
	logic          active_q;
	logic [1:0]    k_q;
	logic [15:0]   entry_q;
	logic [AW-1:0] addr_q;
	logic          is_fill_q;
	logic          bad_q;
	logic [31:0]   fill_word_q;
	logic          frame_end_q;

	logic          decode_fire;
	logic          geo_write;
	logic [1:0]    last_k;
	logic          last_issue;
	logic [AW-1:0] stride_ext;
	logic [AW-1:0] block_step;
	logic [AW-1:0] row_base_n;
	logic          is_fill_in;
	logic          bad_in;
	logic          row_end;
	logic          frame_end;
	logic [AW+23:0] addr_wide;
	logic [17:0]   rd_addr_wide;

	// handshake and issue control
	assign last_k      = tall_q ? 2'd3 : 2'd1;
	assign rd_en       = active_q && space;
	assign last_issue  = rd_en && (k_q == last_k);
	assign in_ready    = !active_q || last_issue;
	assign decode_fire = in_valid && in_ready && (command == CMD_DECODE);
	assign geo_write   = cfg_we && (cfg_index == CFG_TALL_BLOCKS
		|| cfg_index == CFG_BLOCKS_PER_ROW || cfg_index == CFG_BLOCK_ROWS
		|| cfg_index == CFG_ROW_STRIDE);

	// geometry arithmetic
	assign stride_ext = AW'(stride_q);
	assign block_step = tall_q ? AW'({stride_q, 2'b00}) : AW'({stride_q, 1'b0});
	assign row_base_n = row_base_q + block_step;
	assign row_end    = (blocks_left_q <= 11'd1);
	assign frame_end  = row_end && (({1'b0, rows_done_q} + 12'd1) >= {1'b0, brows_q});

	// pointer decode
	assign is_fill_in = (pointer_high == fill_marker_q);
	assign bad_in     = !is_fill_in && ({1'b0, pointer_high, pointer_low} >= ENTRIES);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tall_q        <= 1'b0;
			fill_marker_q <= FILL_MARKER_RST;
			bpr_q         <= BLOCKS_PER_ROW_RST;
			brows_q       <= BLOCK_ROWS_RST;
			stride_q      <= ROW_STRIDE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TALL_BLOCKS:    tall_q        <= cfg_data[0];
				CFG_FILL_MARKER:    fill_marker_q <= cfg_data[7:0];
				CFG_BLOCKS_PER_ROW: bpr_q         <= cfg_data[10:0];
				CFG_BLOCK_ROWS:     brows_q       <= cfg_data[10:0];
				CFG_ROW_STRIDE:     stride_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame position walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q    <= '0;
			column_q      <= '0;
			blocks_left_q <= BLOCKS_PER_ROW_RST;
			rows_done_q   <= '0;
		end else if (geo_write) begin
			row_base_q    <= '0;
			column_q      <= '0;
			blocks_left_q <= (cfg_index == CFG_BLOCKS_PER_ROW) ? cfg_data[10:0] : bpr_q;
			rows_done_q   <= '0;
		end else if (decode_fire) begin
			priority if (frame_end) begin
				row_base_q    <= '0;
				column_q      <= '0;
				blocks_left_q <= bpr_q;
				rows_done_q   <= '0;
			end else if (row_end) begin
				row_base_q    <= row_base_n;
				column_q      <= row_base_n;
				blocks_left_q <= bpr_q;
				rows_done_q   <= rows_done_q + 11'd1;
			end else begin
				column_q      <= column_q + AW'(4);
				blocks_left_q <= blocks_left_q - 11'd1;
			end
		end
	end

	// block control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			k_q      <= '0;
		end else if (decode_fire) begin
			active_q <= 1'b1;
			k_q      <= '0;
		end else if (rd_en) begin
			if (k_q == last_k) begin
				active_q <= 1'b0;
			end
			k_q <= k_q + 2'd1;
		end
	end

	// block payload
	always_ff @(posedge clk) begin
		if (decode_fire) begin
			entry_q     <= {pointer_high, pointer_low};
			addr_q      <= column_q;
			is_fill_q   <= is_fill_in;
			bad_q       <= bad_in;
			fill_word_q <= {4{pointer_low}};
			frame_end_q <= frame_end;
		end else if (rd_en) begin
			addr_q <= addr_q + stride_ext;
		end
	end

	// read address and row word description
	assign rd_addr_wide = {entry_q, k_q};
	assign rd_addr      = rd_addr_wide[SW-1:0];
	assign addr_wide    = {24'b0, addr_q};

	always_comb begin
		meta.byte_address = addr_wide[23:0];
		meta.pixel_word   = is_fill_q ? fill_word_q : 32'd0;
		meta.use_mem      = !is_fill_q && !bad_q;
		meta.block_last   = (k_q == last_k);
		meta.frame_done   = (k_q == last_k) && frame_end_q;
		meta.bad_entry    = bad_q;
	end

	// checks
	`VQCBD_ASSERT_IMP(a_issue_needs_block, rd_en, active_q && space)
	`VQCBD_ASSERT_IMP(a_busy_ready_on_last, in_ready && active_q, last_issue)
	`VQCBD_ASSERT_NXT(a_decode_starts_row0, decode_fire && !geo_write, active_q && k_q == 2'd0)
	`VQCBD_ASSERT_NXT(a_last_row_ends, last_issue && !decode_fire, !active_q)

endmodule

// ===== hw/rtl/vq_codebook_block_decoder_top.sv =====
// Top level of the vq codebook block decoder.
// A decode item's row words pass the block registers, the codebook read register and the
// read stage into the output queue; one word per cycle while that queue has room. A decode
// item has two row words (4x2) or four (4x4), one per read of the single codebook port.
// Reset: registers take their reset values and position returns to address 0 at once;
// the codebook memory is not cleared and holds no data until written.
module vq_codebook_block_decoder_top
	import vqcbd_pkg::*;
#(
	parameter int unsigned CODEBOOK_ENTRIES = 4096,
	parameter int unsigned ADDRESS_BITS     = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  command,
	input  logic [11:0]           entry_number,
	input  logic [1:0]            entry_row,
	input  logic [31:0]           entry_word,
	input  logic [7:0]            pointer_low,
	input  logic [7:0]            pointer_high,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [23:0]           byte_address,
	output logic [31:0]           pixel_word,
	output logic                  block_last,
	output logic                  frame_done,
	output logic                  bad_entry
);

	localparam int unsigned SW = $clog2(CODEBOOK_ENTRIES * 4);
	localparam logic [16:0] ENTRIES = 17'(CODEBOOK_ENTRIES);

	logic                 load_we;
	logic [17:0]          wr_addr_wide;
	logic                 rd_en;
	logic [SW-1:0]        rd_addr;
	logic [31:0]          rd_data;
	row_meta_t            meta;
	row_meta_t            meta_s2;
	logic                 valid_s2;
	out_item_t            push_item;
	out_item_t            head;
	logic [OUT_CNT_W-1:0] fifo_count;
	logic                 space;

	// load items write the store straight away
	assign load_we      = in_valid && in_ready && (command == CMD_LOAD)
		&& ({5'b0, entry_number} < ENTRIES);
	assign wr_addr_wide = {4'b0, entry_number, entry_row};

	// room for one more word counting the one in the read stage
	assign space = (({1'b0, fifo_count} + {{OUT_CNT_W{1'b0}}, valid_s2}) < (OUT_CNT_W + 1)'(OUT_DEPTH));

	vqcbd_sequencer #(
		.CODEBOOK_ENTRIES (CODEBOOK_ENTRIES),
		.ADDRESS_BITS     (ADDRESS_BITS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.command      (command),
		.pointer_low  (pointer_low),
		.pointer_high (pointer_high),
		.space        (space),
		.in_ready     (in_ready),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.meta         (meta)
	);

	vqcbd_codebook #(
		.CODEBOOK_ENTRIES (CODEBOOK_ENTRIES)
	) u_codebook (
		.clk     (clk),
		.wr_en   (load_we),
		.wr_addr (wr_addr_wide[SW-1:0]),
		.wr_data (entry_word),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// read stage alongside the memory output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			meta_s2 <= meta;
		end
	end

	// pick stored word or fill/zero word
	always_comb begin
		push_item.byte_address = meta_s2.byte_address;
		push_item.pixel_word   = meta_s2.use_mem ? rd_data : meta_s2.pixel_word;
		push_item.block_last   = meta_s2.block_last;
		push_item.frame_done   = meta_s2.frame_done;
		push_item.bad_entry    = meta_s2.bad_entry;
	end

	vqcbd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s2),
		.push_item (push_item),
		.pop       (out_valid && out_ready),
		.not_empty (out_valid),
		.head      (head),
		.count     (fifo_count)
	);

	assign byte_address = head.byte_address;
	assign pixel_word   = head.pixel_word;
	assign block_last   = head.block_last;
	assign frame_done   = head.frame_done;
	assign bad_entry    = head.bad_entry;

endmodule

// ===== sim/tb_vq_codebook_block_decoder_top.sv =====
// self-checking testbench for the vq codebook block decoder top level
`timescale 1ns / 100ps

module tb_vq_codebook_block_decoder_top;
	import vqcbd_pkg::*;

	localparam int unsigned CB_ENTRIES = 4096;
	localparam int unsigned LONG_HOLD  = 150;

	// one input item as queued for the driver
	typedef struct {
		logic        cmd;
		logic [11:0] num;
		logic [1:0]  row;
		logic [31:0] word;
		logic [7:0]  lo;
		logic [7:0]  hi;
	} vq_cmd_t;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index    = '0;
	logic [CFG_DATA_W-1:0] cfg_data     = '0;
	logic                  in_valid     = 1'b0;
	logic                  in_ready;
	logic                  command      = CMD_LOAD;
	logic [11:0]           entry_number = '0;
	logic [1:0]            entry_row    = '0;
	logic [31:0]           entry_word   = '0;
	logic [7:0]            pointer_low  = '0;
	logic [7:0]            pointer_high = '0;
	logic                  out_valid;
	logic                  out_ready    = 1'b0;
	logic [23:0]           byte_address;
	logic [31:0]           pixel_word;
	logic                  block_last;
	logic                  frame_done;
	logic                  bad_entry;

	vq_codebook_block_decoder_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.entry_number (entry_number),
		.entry_row    (entry_row),
		.entry_word   (entry_word),
		.pointer_low  (pointer_low),
		.pointer_high (pointer_high),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_address (byte_address),
		.pixel_word   (pixel_word),
		.block_last   (block_last),
		.frame_done   (frame_done),
		.bad_entry    (bad_entry)
	);

	// mirror of the registers, position and codebook
	logic        mirror_tall;
	logic [7:0]  mirror_fill;
	logic [10:0] mirror_bpr;
	logic [10:0] mirror_block_rows;
	logic [12:0] mirror_stride;
	logic [23:0] pos_row_base;
	logic [23:0] pos_col;
	int unsigned pos_blocks_left;
	int unsigned pos_rows_done;
	logic [31:0] cb_mirror [0:CB_ENTRIES*4-1];

	vq_cmd_t     pending_items [$];
	out_item_t   expected_words [$];
	out_item_t   head_word;
	vq_cmd_t     next_item;
	int unsigned errors       = 0;
	int unsigned decodes_sent = 0;
	bit          burst_mode   = 1'b0;
	int unsigned gap_left;
	int unsigned stall_left;
	int unsigned hold_left;
	int unsigned holds_done;

	// stimulus-side record of which codebook entries are fully loaded
	bit [3:0]    gen_rows_loaded [0:CB_ENTRIES-1];
	bit          gen_listed [0:CB_ENTRIES-1];
	int unsigned ready_entries [$];

	initial begin
		forever #2 clk = ~clk;
	end

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void restart_position();
		pos_row_base    = '0;
		pos_col         = '0;
		pos_blocks_left = mirror_bpr;
		pos_rows_done   = 0;
	endfunction

	// expected row words of one decode item, then advance the position
	function automatic void predict_block_words(logic [7:0] lo, logic [7:0] hi);
		int unsigned nrows;
		int unsigned entry;
		logic        is_fill;
		logic        out_of_range;
		logic        row_end;
		logic        frame_end;
		out_item_t   w;
		nrows        = mirror_tall ? 4 : 2;
		is_fill      = (hi == mirror_fill);
		entry        = {hi, lo};
		out_of_range = !is_fill && (entry >= CB_ENTRIES);
		row_end      = (pos_blocks_left <= 1);
		frame_end    = row_end && (pos_rows_done + 1 >= mirror_block_rows);
		for (int k = 0; k < nrows; k++) begin
			w.byte_address = pos_col + 24'(k * mirror_stride);
			if (is_fill)
				w.pixel_word = {4{lo}};
			else if (out_of_range)
				w.pixel_word = '0;
			else
				w.pixel_word = cb_mirror[entry * 4 + k];
			w.block_last = (k == nrows - 1);
			w.frame_done = w.block_last && frame_end;
			w.bad_entry  = out_of_range;
			expected_words.push_back(w);
		end
		if (frame_end) begin
			restart_position();
		end else if (row_end) begin
			pos_row_base    = pos_row_base + 24'(nrows * mirror_stride);
			pos_col         = pos_row_base;
			pos_blocks_left = mirror_bpr;
			pos_rows_done   = (pos_rows_done + 1) & 11'h7FF;
		end else begin
			pos_col         = pos_col + 24'd4;
			pos_blocks_left = pos_blocks_left - 1;
		end
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// register write, only called while the block is idle
	task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			CFG_TALL_BLOCKS: begin
				mirror_tall = val[0];
				restart_position();
			end
			CFG_FILL_MARKER: begin
				mirror_fill = val[7:0];
			end
			CFG_BLOCKS_PER_ROW: begin
				mirror_bpr = val[10:0];
				restart_position();
			end
			CFG_BLOCK_ROWS: begin
				mirror_block_rows = val[10:0];
				restart_position();
			end
			CFG_ROW_STRIDE: begin
				mirror_stride = val[12:0];
				restart_position();
			end
			default: begin
			end
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic queue_load(logic [11:0] num, logic [1:0] row, logic [31:0] word);
		vq_cmd_t c;
		c.cmd  = CMD_LOAD;
		c.num  = num;
		c.row  = row;
		c.word = word;
		c.lo   = 8'($urandom());
		c.hi   = 8'($urandom());
		pending_items.push_back(c);
		gen_rows_loaded[num][row] = 1'b1;
		if (&gen_rows_loaded[num] && !gen_listed[num]) begin
			gen_listed[num] = 1'b1;
			ready_entries.push_back(num);
		end
	endtask

	task automatic queue_decode(logic [7:0] lo, logic [7:0] hi);
		vq_cmd_t c;
		c.cmd  = CMD_DECODE;
		c.num  = 12'($urandom());
		c.row  = 2'($urandom());
		c.word = $urandom();
		c.lo   = lo;
		c.hi   = hi;
		pending_items.push_back(c);
	endtask

	// wait until every queued item is in and every expected word is out
	task automatic drain_block();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_words.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	// input driver: predicts on each handshake, then offers the next item
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				if (command == CMD_DECODE) begin
					predict_block_words(pointer_low, pointer_high);
					decodes_sent++;
				end else begin
					cb_mirror[{entry_number, entry_row}] = entry_word;
				end
			end
			if (!in_valid || in_ready) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					in_valid     <= 1'b1;
					command      <= next_item.cmd;
					entry_number <= next_item.num;
					entry_row    <= next_item.row;
					entry_word   <= next_item.word;
					pointer_low  <= next_item.lo;
					pointer_high <= next_item.hi;
					gap_left     <= burst_mode ? 0 : idle_len();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// output monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
			holds_done <= 0;
		end else begin
			// compare the result item with the oldest expectation
			if (out_valid && out_ready) begin
				if (expected_words.size() == 0) begin
					$display("%0t: item with nothing expected: addr %h word %h",
						$time, byte_address, pixel_word);
					errors++;
				end else begin
					head_word = expected_words.pop_front();
					check_field("byte_address", head_word.byte_address, byte_address);
					check_field("pixel_word", head_word.pixel_word, pixel_word);
					check_field("block_last", head_word.block_last, block_last);
					check_field("frame_done", head_word.frame_done, frame_done);
					check_field("bad_entry", head_word.bad_entry, bad_entry);
				end
			end
			// long hold-offs while the sender keeps offering, otherwise random stalls
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (holds_done < 2 && pending_items.size() >= 8 &&
					decodes_sent >= (holds_done == 0 ? 30 : 160)) begin
				out_ready  <= 1'b0;
				hold_left  <= LONG_HOLD;
				holds_done <= holds_done + 1;
			end else if (stall_left != 0) begin
				out_ready  <= 1'b0;
				stall_left <= stall_left - 1;
			end else if (!burst_mode && $urandom_range(0, 4) == 0) begin
				out_ready  <= 1'b0;
				stall_left <= idle_len();
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// stimulus and end of run
	initial begin : stimulus
		int unsigned n;
		int unsigned pick;
		int unsigned e;
		int unsigned r0;
		bit          mid_done;
		mirror_tall       = 1'b0;
		mirror_fill       = FILL_MARKER_RST;
		mirror_bpr        = BLOCKS_PER_ROW_RST;
		mirror_block_rows = BLOCK_ROWS_RST;
		mirror_stride     = ROW_STRIDE_RST;
		restart_position();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: extreme words and entries, fill and out-of-range pointers
		queue_load(12'd0, 2'd0, 32'h0000_0000);
		queue_load(12'd0, 2'd1, 32'hFFFF_FFFF);
		queue_load(12'd0, 2'd2, 32'h0123_4567);
		queue_load(12'd0, 2'd3, 32'h89AB_CDEF);
		queue_load(12'd4095, 2'd3, 32'hFFFF_FFFF);
		queue_load(12'd4095, 2'd2, 32'h8000_0001);
		queue_load(12'd4095, 2'd1, 32'h7FFF_FFFE);
		queue_load(12'd4095, 2'd0, 32'h5A5A_A5A5);
		queue_decode(8'd0, 8'd0);
		queue_decode(8'd255, 8'd15);
		queue_decode(8'd0, 8'd16);
		queue_decode(8'd255, 8'd255);
		drain_block();

		// tall blocks, tiny frame so it wraps, stride of 4096, unknown indexes
		set_register(CFG_TALL_BLOCKS, 13'd1);
		set_register(CFG_FILL_MARKER, 13'd255);
		set_register(CFG_BLOCKS_PER_ROW, 13'd2);
		set_register(CFG_BLOCK_ROWS, 13'd2);
		set_register(CFG_ROW_STRIDE, 13'd4096);
		set_register(3'd7, 13'h1FFF);
		set_register(3'd5, 13'd0);
		queue_decode(8'd255, 8'd15);
		queue_decode(8'hA5, 8'd255);
		queue_decode(8'd255, 8'd254);
		queue_decode(8'd0, 8'd0);
		queue_decode(8'd0, 8'd0);
		drain_block();

		// fill marker change keeps the position
		set_register(CFG_FILL_MARKER, 13'd0);
		queue_decode(8'h3C, 8'd0);
		queue_decode(8'd255, 8'd15);
		drain_block();

		// zero counts behave as one: every block ends the frame
		set_register(CFG_TALL_BLOCKS, 13'd0);
		set_register(CFG_BLOCKS_PER_ROW, 13'd0);
		set_register(CFG_BLOCK_ROWS, 13'd0);
		set_register(CFG_ROW_STRIDE, 13'd4);
		queue_decode(8'd0, 8'd0);
		queue_decode(8'h81, 8'd0);

		// random phases over several geometries
		for (int p = 0; p < 6; p++) begin
			drain_block();
			burst_mode = (p == 4);
			set_register(CFG_TALL_BLOCKS, CFG_DATA_W'(p % 2));
			set_register(CFG_FILL_MARKER, CFG_DATA_W'($urandom_range(0, 1) ?
				$urandom_range(0, 15) : $urandom_range(16, 255)));
			set_register(CFG_BLOCKS_PER_ROW, CFG_DATA_W'(p == 0 ? 1 :
				p == 1 ? 1024 : $urandom_range(1, 6)));
			set_register(CFG_BLOCK_ROWS, CFG_DATA_W'(p == 0 ? 1 :
				p == 1 ? 1024 : $urandom_range(1, 4)));
			set_register(CFG_ROW_STRIDE, CFG_DATA_W'(p == 0 ? 4 : p == 1 ? 4096 :
				p == 5 ? 8191 : $urandom_range(4, 4096)));
			if (p == 2)
				set_register(3'd6, CFG_DATA_W'($urandom()));
			n = 0;
			mid_done = 1'b0;
			while (n < 70) begin
				pick = $urandom_range(0, 99);
				if (pick < 25) begin
					// a whole entry, rows in rotated order
					e  = $urandom_range(0, CB_ENTRIES - 1);
					r0 = $urandom_range(0, 3);
					for (int k = 0; k < 4; k++)
						queue_load(12'(e), 2'(r0 + k), $urandom());
					n += 4;
				end else if (pick < 35) begin
					queue_load(12'($urandom()), 2'($urandom()), $urandom());
					n++;
				end else if (pick < 62 && ready_entries.size() != 0) begin
					e = ready_entries[$urandom_range(0, ready_entries.size() - 1)];
					queue_decode(8'(e), 8'(e >> 8));
					n++;
				end else if (pick < 80) begin
					queue_decode(8'($urandom()), mirror_fill);
					n++;
				end else begin
					queue_decode(8'($urandom()), 8'($urandom_range(16, 255)));
					n++;
				end
				// mid-frame fill marker change
				if (p == 3 && n >= 35 && !mid_done) begin
					drain_block();
					set_register(CFG_FILL_MARKER, CFG_DATA_W'($urandom_range(0, 255)));
					mid_done = 1'b1;
				end
			end
		end

		drain_block();
		repeat (20) @(negedge clk);
		if (errors == 0 && expected_words.size() == 0)
			$display("** vq_codebook_block_decoder_top: PASSED **");
		else
			$display("** vq_codebook_block_decoder_top: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#(4_000_000);
		$display("** vq_codebook_block_decoder_top: FAILED **");
		$finish;
	end

endmodule
